// ----- rtl/core/chs_pkg.sv -----
// Package: shared constants, codes and types for the chained hash set.
`default_nettype none
package chs_pkg;

	localparam int NUM_BUCKETS  = 5;
	localparam int BUCKET_DEPTH = 8;

	localparam int KEY_W  = 32;
	localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
	localparam int SLOT_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int ROW_W  = KEY_W * BUCKET_DEPTH;

	// Modulo reduction: byte fold to SUM_W bits, then reciprocal multiply.
	localparam int SUM_W   = 16;
	localparam int SHIFT   = SUM_W + 7;
	localparam int RECIP_W = SHIFT + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	localparam logic [SUM_W-1:0] WGT0 = SUM_W'(1 % NUM_BUCKETS);
	localparam logic [SUM_W-1:0] WGT1 = SUM_W'(256 % NUM_BUCKETS);
	localparam logic [SUM_W-1:0] WGT2 = SUM_W'((int'(WGT1) * 256) % NUM_BUCKETS);
	localparam logic [SUM_W-1:0] WGT3 = SUM_W'((int'(WGT2) * 256) % NUM_BUCKETS);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / NUM_BUCKETS);
	localparam logic [SUM_W-1:0] NB_S = SUM_W'(NUM_BUCKETS);
	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(BUCKET_DEPTH);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH1,
		S_HASH2,
		S_HASH3,
		S_READ,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic hash1;
		logic hash2;
		logic hash3;
		logic mem_rd;
		logic exec;
	} chs_ctl_t;

	typedef struct packed {
		logic out_free;
	} chs_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/chs_req_if.sv -----
// Interface: request channel (command and key).
`default_nettype none
interface chs_req_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [chs_pkg::KEY_W-1:0]   key;

	modport source (output valid, output cmd, output key, input ready);
	modport sink (input valid, input cmd, input key, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/chs_rsp_if.sv -----
// Interface: response channel (status and bucket index).
`default_nettype none
interface chs_rsp_if;
	logic                        valid;
	logic                        ready;
	chs_pkg::status_t            status;
	logic [chs_pkg::BKT_W-1:0]   bucket_index;

	modport source (output valid, output status, output bucket_index, input ready);
	modport sink (input valid, input status, input bucket_index, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/chs_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module chs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- rtl/core/chs_ctrl.sv -----
// Controller: sequences one request through hash, row read and update.
`default_nettype none
module chs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire chs_pkg::chs_sts_t sts,
	output chs_pkg::chs_ctl_t      ctl
);
	import chs_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_HASH1;
				end
			end
			S_HASH1: begin
				ctl.hash1 = 1'b1;
				state_d   = S_HASH2;
			end
			S_HASH2: begin
				ctl.hash2 = 1'b1;
				state_d   = S_HASH3;
			end
			S_HASH3: begin
				ctl.hash3 = 1'b1;
				state_d   = S_READ;
			end
			S_READ: begin
				ctl.mem_rd = 1'b1;
				state_d    = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) begin
					ctl.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_accept_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_HASH1))
		else $error("accepted request did not start hashing");

	a_exec_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> sts.out_free)
		else $error("update issued while result register busy");
endmodule
`default_nettype wire

// ----- rtl/core/chs_dp.sv -----
// Datapath: bucket modulo, fill counts, key row RAM, compare and result register.
`default_nettype none
module chs_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_cmd,
	input  wire logic [chs_pkg::KEY_W-1:0]  req_key,
	input  wire chs_pkg::chs_ctl_t          ctl,
	output chs_pkg::chs_sts_t               sts,
	chs_rsp_if.source                       rsp
);
	import chs_pkg::*;

	logic              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  quo_q;
	logic [BKT_W-1:0]  bucket_q;
	logic [FILL_W-1:0] fill_q [NUM_BUCKETS];
	logic [FILL_W-1:0] fill_cur_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [BKT_W-1:0]  bkt_out_q;

	logic [SUM_W-1:0]  sum_d;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  rem;
	logic [SUM_W-1:0]  rem_fix;
	logic [ROW_W-1:0]  row_rd;
	logic [ROW_W-1:0]  row_wr;
	logic              hit;
	logic              full;
	logic              ram_we;

	// Byte fold: sum of bytes weighted by 256^i mod N.
	always_comb begin
		sum_d = SUM_W'(key_q[7:0])   * WGT0
		      + SUM_W'(key_q[15:8])  * WGT1
		      + SUM_W'(key_q[23:16]) * WGT2
		      + SUM_W'(key_q[31:24]) * WGT3;
	end

	assign prod    = PROD_W'(sum_q) * PROD_W'(RECIP);
	assign rem     = sum_q - SUM_W'(quo_q * NB_S);
	assign rem_fix = (rem >= NB_S) ? (rem - NB_S) : rem;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req_cmd;
			key_q <= req_key;
		end
		if (ctl.hash1) begin
			sum_q <= sum_d;
		end
		if (ctl.hash2) begin
			quo_q <= prod[SHIFT +: SUM_W];
		end
		if (ctl.hash3) begin
			bucket_q <= BKT_W'(rem_fix);
		end
		if (ctl.mem_rd) begin
			fill_cur_q <= fill_q[bucket_q];
		end
	end

	assign full = (fill_cur_q >= DEPTH_F);

	always_comb begin
		hit    = 1'b0;
		row_wr = row_rd;
		for (int j = 0; j < BUCKET_DEPTH; j++) begin
			if ((FILL_W'(j) < fill_cur_q) && (row_rd[j*KEY_W +: KEY_W] == key_q)) begin
				hit = 1'b1;
			end
			if (FILL_W'(j) == fill_cur_q) begin
				row_wr[j*KEY_W +: KEY_W] = key_q;
			end
		end
	end

	assign ram_we = ctl.exec && (cmd_q == CMD_INSERT) && !full;

	chs_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_BUCKETS)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ctl.mem_rd),
		.addr  (bucket_q),
		.wdata (row_wr),
		.rdata (row_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUCKETS; b++) begin
				fill_q[b] <= '0;
			end
		end else if (ram_we) begin
			fill_q[bucket_q] <= fill_cur_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			bkt_out_q <= bucket_q;
			if (cmd_q == CMD_INSERT) begin
				status_q <= full ? ST_FULL : ST_INSERTED;
			end else begin
				status_q <= hit ? ST_FOUND : ST_NOT_FOUND;
			end
		end
	end

	assign sts.out_free    = !out_valid_q || rsp.ready;
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.bucket_index = bkt_out_q;

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> (fill_cur_q <= DEPTH_F))
		else $error("bucket fill count above depth");

	a_bucket_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mem_rd |-> (bucket_q < BKT_W'(NUM_BUCKETS)))
		else $error("bucket index out of range");

	a_write_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (fill_q[$past(bucket_q)] == $past(fill_cur_q) + FILL_W'(1)))
		else $error("fill count not advanced after insert");
endmodule
`default_nettype wire

// ----- rtl/core/chained_hash_set_top.sv -----
// Top level: chained hash set of 32-bit keys with bounded buckets.
// Each request (insert or lookup) passes through an accept step, bucket-index modulo
// reduction (byte fold, reciprocal multiply, correction) in states S_HASH1 to S_HASH3,
// a row read of the bucket RAM and a compare/update step that writes the result into
// the output register. The compare/update step waits while an earlier result still
// sits untaken in the output register. A new request is not accepted until the
// previous one has finished its update; the next request is accepted while the
// previous result still waits.
// Each bucket is one RAM row holding all its key slots; per-bucket fill counts reset
// to zero, and the key RAM needs no clearing pass.
`default_nettype none
module chained_hash_set_top (
	input  wire logic clk,
	input  wire logic arst_n,
	chs_req_if.sink   req,
	chs_rsp_if.source rsp
);
	import chs_pkg::*;

	chs_ctl_t ctl;
	chs_sts_t sts;
	logic     in_ready;

	assign req.ready = in_ready;

	chs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	chs_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_cmd (req.cmd),
		.req_key (req.key),
		.ctl     (ctl),
		.sts     (sts),
		.rsp     (rsp)
	);
endmodule
`default_nettype wire
